FILE: hw/rtl/motion_adaptive_temporal_blend_core_defines.svh
// Assertion macros shared by the blend core checkers.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef MOTION_ADAPTIVE_TEMPORAL_BLEND_CORE_DEFINES_SVH
`define MOTION_ADAPTIVE_TEMPORAL_BLEND_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MATB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MATB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/matb_pkg.sv
// Package of the temporal blend core: widths, register codes, payload types.
// No dependencies; imported by every module of the core.
package matb_pkg;

    localparam int PIX_W       = 8;
    localparam int THR_W       = 8;
    localparam int WGT_W       = 9;
    localparam int PROD_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_STAGES  = 3;
    localparam int DIV_STEPS   = 3;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 9'd256;

    localparam logic [THR_W-1:0] RST_LOW_THR  = 8'd16;
    localparam logic [THR_W-1:0] RST_HIGH_THR = 8'd32;
    localparam logic [WGT_W-1:0] RST_LOW_WGT  = 9'd128;
    localparam logic [WGT_W-1:0] RST_HIGH_WGT = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THR  = 2'd0,
        CFG_HIGH_THR = 2'd1,
        CFG_LOW_WGT  = 2'd2,
        CFG_HIGH_WGT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0] low_thr;
        logic [THR_W-1:0] high_thr;
        logic [WGT_W-1:0] low_wgt;
        logic [WGT_W-1:0] high_wgt;
    } t_cfg;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [PROD_W-1:0] dsr;
        logic [WGT_W-1:0]  quo;
        logic              lo;
        logic              hi;
        logic [PIX_W-1:0]  prev;
        logic [PIX_W-1:0]  cur;
    } t_div;

    function automatic logic [WGT_W-1:0] sat_weight(input logic [WGT_W-1:0] v);
        return (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
    endfunction

endpackage

FILE: hw/rtl/matb_weight.sv
// Front end of the blend core: absolute difference, ramp products, dividend.
// Depends on matb_pkg.
module matb_weight (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  matb_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [matb_pkg::PIX_W-1:0]   i_prev,
    input  logic [matb_pkg::PIX_W-1:0]   i_cur,
    output logic                         o_valid,
    input  logic                         i_ready,
    output matb_pkg::t_div               o_data
);
    import matb_pkg::*;

    logic              r_v1, r_v2, r_v3;
    logic [PIX_W-1:0]  r_prev1, r_cur1, r_d1;
    logic [PIX_W-1:0]  r_prev2, r_cur2;
    logic [PROD_W-1:0] r_pa2, r_pb2;
    logic              r_lo2, r_hi2;
    logic [THR_W-1:0]  r_den2;
    t_div              r_data3;

    logic              rdy1, rdy2, rdy3;
    logic [PIX_W-1:0]  n_d1;
    logic [THR_W-1:0]  t_high, t_low;
    logic [PROD_W-1:0] n_pa2, n_pb2;
    t_div              n_data3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_data3;

    assign n_d1   = (i_prev > i_cur) ? (i_prev - i_cur) : (i_cur - i_prev);
    assign t_high = i_cfg.high_thr - r_d1;
    assign t_low  = r_d1 - i_cfg.low_thr;
    assign n_pa2  = PROD_W'(sat_weight(i_cfg.low_wgt)) * PROD_W'(t_high);
    assign n_pb2  = PROD_W'(sat_weight(i_cfg.high_wgt)) * PROD_W'(t_low);

    always_comb begin
        n_data3      = '0;
        n_data3.rem  = r_pa2 + r_pb2;
        n_data3.dsr  = {1'b0, r_den2, 8'b0};
        n_data3.quo  = '0;
        n_data3.lo   = r_lo2;
        n_data3.hi   = r_hi2;
        n_data3.prev = r_prev2;
        n_data3.cur  = r_cur2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_prev1 <= i_prev;
            r_cur1  <= i_cur;
            r_d1    <= n_d1;
        end
        if (rdy2 && r_v1) begin
            r_prev2 <= r_prev1;
            r_cur2  <= r_cur1;
            r_lo2   <= (r_d1 <= i_cfg.low_thr);
            r_hi2   <= (r_d1 > i_cfg.high_thr);
            r_den2  <= i_cfg.high_thr - i_cfg.low_thr;
            r_pa2   <= n_pa2;
            r_pb2   <= n_pb2;
        end
        if (rdy3 && r_v2) begin
            r_data3 <= n_data3;
        end
    end

endmodule

FILE: hw/rtl/matb_div_stage.sv
// One registered stage of the ramp divider: a few restoring quotient bits.
// Depends on matb_pkg.
module matb_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  matb_pkg::t_div i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output matb_pkg::t_div o_data
);
    import matb_pkg::*;

    logic r_v;
    t_div r_data;
    t_div n_data;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (n_data.rem >= n_data.dsr) begin
                n_data.rem = n_data.rem - n_data.dsr;
                n_data.quo = {n_data.quo[WGT_W-2:0], 1'b1};
            end else begin
                n_data.quo = {n_data.quo[WGT_W-2:0], 1'b0};
            end
            n_data.dsr = n_data.dsr >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: hw/rtl/matb_mix.sv
// Back end of the blend core: weight select, weighted products, output register.
// Depends on matb_pkg.
module matb_mix (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  matb_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  matb_pkg::t_div              i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [matb_pkg::PIX_W-1:0]  o_pix
);
    import matb_pkg::*;

    logic              r_va, r_vb;
    logic [PROD_W-1:0] r_pi, r_pw;
    logic [PIX_W-1:0]  r_pix;

    logic              rdy_a, rdy_b;
    logic              ramp, round_dn;
    logic [WGT_W-1:0]  w, inv;
    logic [PROD_W-1:0] sum;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_pix   = r_pix;

    always_comb begin
        ramp     = !i_data.lo && !i_data.hi;
        round_dn = ramp && (i_data.rem != '0) && (i_data.quo != WEIGHT_ONE);
        if (i_data.lo) begin
            w = sat_weight(i_cfg.low_wgt);
        end else if (i_data.hi) begin
            w = sat_weight(i_cfg.high_wgt);
        end else begin
            w = i_data.quo;
        end
        inv = WEIGHT_ONE - w - WGT_W'(round_dn);
    end

    assign sum = r_pi + r_pw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_pi <= PROD_W'(inv) * PROD_W'(i_data.prev);
            r_pw <= PROD_W'(w) * PROD_W'(i_data.cur);
        end
        if (rdy_b && r_va) begin
            r_pix <= sum[2*PIX_W-1:PIX_W];
        end
    end

endmodule

FILE: hw/rtl/motion_adaptive_temporal_blend_core.sv
// Top level of the motion-adaptive temporal blend core: registers and pipeline.
// Depends on matb_pkg, matb_weight, matb_div_stage and matb_mix.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  pixel in | i_valid / o_stall          | i_previous_pixel, i_current_pixel
//  pixel out| o_valid / i_stall          | o_blended_pixel
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One transaction per cycle while o_stall is low; the pipeline from accept to o_valid is
// 3 front-end stages, 3 divider stages of 3 quotient bits and 2 mix stages.
// Reset empties the pipeline and loads the register defaults.
// Each stage holds only while its successor is full, so bubbles collapse;
// o_stall rises only with all stages full and the output stalled.
module motion_adaptive_temporal_blend_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [matb_pkg::PIX_W-1:0]        i_previous_pixel,
    input  logic [matb_pkg::PIX_W-1:0]        i_current_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [matb_pkg::PIX_W-1:0]        o_blended_pixel,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [matb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [matb_pkg::WGT_W-1:0]        i_cfg_data
);
    import matb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic in_ready;
    logic v_div   [0:DIV_STAGES];
    logic rdy_div [0:DIV_STAGES];
    t_div d_div   [0:DIV_STAGES];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !in_ready;

    always_comb begin
        n_cfg = r_cfg;
        unique case (t_cfg_idx'(i_cfg_index))
            CFG_LOW_THR:  n_cfg.low_thr  = i_cfg_data[THR_W-1:0];
            CFG_HIGH_THR: n_cfg.high_thr = i_cfg_data[THR_W-1:0];
            CFG_LOW_WGT:  n_cfg.low_wgt  = i_cfg_data;
            CFG_HIGH_WGT: n_cfg.high_wgt = i_cfg_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr  <= RST_LOW_THR;
            r_cfg.high_thr <= RST_HIGH_THR;
            r_cfg.low_wgt  <= RST_LOW_WGT;
            r_cfg.high_wgt <= RST_HIGH_WGT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= n_cfg;
        end
    end

    matb_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (in_ready),
        .i_prev  (i_previous_pixel),
        .i_cur   (i_current_pixel),
        .o_valid (v_div[0]),
        .i_ready (rdy_div[0]),
        .o_data  (d_div[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        matb_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_div[g]),
            .o_ready (rdy_div[g]),
            .i_data  (d_div[g]),
            .o_valid (v_div[g+1]),
            .i_ready (rdy_div[g+1]),
            .o_data  (d_div[g+1])
        );
    end

    matb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (v_div[DIV_STAGES]),
        .o_ready (rdy_div[DIV_STAGES]),
        .i_data  (d_div[DIV_STAGES]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_pix   (o_blended_pixel)
    );

endmodule

FILE: hw/rtl/matb_checker.sv
// Port-level checker for the blend core, bound to the top level.
// Depends on matb_pkg and motion_adaptive_temporal_blend_core_defines.svh.
`include "motion_adaptive_temporal_blend_core_defines.svh"

module matb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [matb_pkg::PIX_W-1:0]        o_blended_pixel,
    input logic                              o_cfg_ready
);
    `MATB_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_blended_pixel))
    `MATB_ASSERT_NOW(a_stall_full, o_stall, o_valid && i_stall)
    `MATB_ASSERT_NOW(a_cfg_open, 1'b1, o_cfg_ready)
    `MATB_ASSERT_NOW(a_ctrl_known, 1'b1, !$isunknown({i_valid, o_valid, o_stall}))
endmodule

bind motion_adaptive_temporal_blend_core matb_checker u_matb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_blended_pixel (o_blended_pixel),
    .o_cfg_ready     (o_cfg_ready)
);

FILE: sim/motion_adaptive_temporal_blend_core_tb.sv
// Self-checking testbench of motion_adaptive_temporal_blend_core: a directed table, then
// random register settings and pixel pairs, each output checked against a known table pixel or a blend predictor.
// Depends on matb_pkg and the core RTL.
module motion_adaptive_temporal_blend_core_tb;
    import matb_pkg::*;

    localparam int RANDOM_PAIRS = 1650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_ROWS       = 38;

    typedef enum logic {ROW_PAIR, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [8:0] a;
        logic [8:0] b;
        logic       known;
        logic [7:0] pixel;
    } t_row;

    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_PAIR, 9'd0,   9'd0,   1'b1, 8'd0},
        '{ROW_PAIR, 9'd255, 9'd255, 1'b1, 8'd255},
        '{ROW_PAIR, 9'd0,   9'd255, 1'b1, 8'd255},
        '{ROW_PAIR, 9'd255, 9'd0,   1'b1, 8'd0},
        '{ROW_PAIR, 9'd16,  9'd0,   1'b1, 8'd8},
        '{ROW_PAIR, 9'd17,  9'd0,   1'b0, 8'd0},
        '{ROW_PAIR, 9'd0,   9'd24,  1'b0, 8'd0},
        '{ROW_PAIR, 9'd32,  9'd0,   1'b1, 8'd0},
        '{ROW_PAIR, 9'd0,   9'd33,  1'b1, 8'd33},
        '{ROW_REG,  9'(CFG_LOW_THR),  9'd0,   1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_THR), 9'd255, 1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_LOW_WGT),  9'd0,   1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_WGT), 9'd256, 1'b0, 8'd0},
        '{ROW_PAIR, 9'd0,   9'd255, 1'b1, 8'd255},
        '{ROW_PAIR, 9'd128, 9'd0,   1'b0, 8'd0},
        '{ROW_PAIR, 9'd77,  9'd77,  1'b1, 8'd77},
        '{ROW_REG,  9'(CFG_LOW_WGT),  9'd511, 1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_WGT), 9'd300, 1'b0, 8'd0},
        '{ROW_PAIR, 9'd10,  9'd20,  1'b1, 8'd20},
        '{ROW_REG,  9'(CFG_LOW_THR),  9'd100, 1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_THR), 9'd50,  1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_LOW_WGT),  9'd0,   1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_WGT), 9'd256, 1'b0, 8'd0},
        '{ROW_PAIR, 9'd100, 9'd0,   1'b1, 8'd100},
        '{ROW_PAIR, 9'd101, 9'd0,   1'b1, 8'd0},
        '{ROW_PAIR, 9'd0,   9'd51,  1'b1, 8'd0},
        '{ROW_REG,  9'(CFG_LOW_THR),  9'h1FF, 1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_THR), 9'h1FF, 1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_LOW_WGT),  9'd256, 1'b0, 8'd0},
        '{ROW_PAIR, 9'd0,   9'd255, 1'b1, 8'd255},
        '{ROW_REG,  9'(CFG_LOW_THR),  9'd0,   1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_THR), 9'd3,   1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_LOW_WGT),  9'd256, 1'b0, 8'd0},
        '{ROW_REG,  9'(CFG_HIGH_WGT), 9'd0,   1'b0, 8'd0},
        '{ROW_PAIR, 9'd255, 9'd254, 1'b0, 8'd0},
        '{ROW_PAIR, 9'd0,   9'd2,   1'b0, 8'd0},
        '{ROW_PAIR, 9'd200, 9'd197, 1'b1, 8'd200},
        '{ROW_PAIR, 9'd255, 9'd0,   1'b1, 8'd255}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [PIX_W-1:0]   i_previous_pixel;
    logic [PIX_W-1:0]   i_current_pixel;
    logic               o_valid;
    logic               i_stall;
    logic [PIX_W-1:0]   o_blended_pixel;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WGT_W-1:0]   i_cfg_data;

    logic [THR_W-1:0]   model_low_thr;
    logic [THR_W-1:0]   model_high_thr;
    logic [WGT_W-1:0]   model_low_wgt;
    logic [WGT_W-1:0]   model_high_wgt;

    logic [PIX_W-1:0]   blend_expected [$];
    logic               pair_known;
    logic [PIX_W-1:0]   pair_known_pixel;
    logic [PIX_W-1:0]   got_pixel;
    logic [PIX_W-1:0]   want_pixel;
    logic               quiet;
    logic               hold_req;
    logic               hold_done;
    int                 hold_left;
    int                 mismatch_count;
    int                 cycle_count;
    int                 pairs_sent;

    motion_adaptive_temporal_blend_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_previous_pixel (i_previous_pixel),
        .i_current_pixel  (i_current_pixel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_blended_pixel  (o_blended_pixel),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic int clamp_weight(input logic [WGT_W-1:0] v);
        return (v > 9'd256) ? 256 : int'(v);
    endfunction

    function automatic logic [PIX_W-1:0] blend_pixel(input logic [PIX_W-1:0] prev,
                                                     input logic [PIX_W-1:0] cur);
        int pv, cv, d, lo, hi, a, b, w, inv, den, num, q, r;
        pv = int'(prev);
        cv = int'(cur);
        d  = (pv > cv) ? pv - cv : cv - pv;
        lo = int'(model_low_thr);
        hi = int'(model_high_thr);
        a  = clamp_weight(model_low_wgt);
        b  = clamp_weight(model_high_wgt);
        if (d <= lo) begin
            w   = a;
            inv = 256 - a;
        end else if (d > hi) begin
            w   = b;
            inv = 256 - b;
        end else begin
            den = hi - lo;
            num = a * den + (b - a) * (d - lo);
            if (num < 0) begin
                num = 0;
            end
            q = num / den;
            r = num % den;
            if (q > 256) begin
                q = 256;
                r = 0;
            end
            w   = q;
            inv = 256 - q;
            if (r != 0 && inv > 0) begin
                inv = inv - 1;
            end
        end
        return PIX_W'((inv * pv + w * cv) >> 8);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] %s: got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_pair(input logic [PIX_W-1:0] prev, input logic [PIX_W-1:0] cur,
                             input logic known, input logic [PIX_W-1:0] known_pixel);
        while (!quiet && $urandom_range(0, 99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_previous_pixel <= prev;
        i_current_pixel  <= cur;
        pair_known       <= known;
        pair_known_pixel <= known_pixel;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pairs_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [WGT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (blend_expected.size() != 0);
    endtask

    task automatic random_settings();
        logic [WGT_W-1:0] lo, hi;
        logic [WGT_W-1:0] wgt [2];
        case ($urandom_range(0, 5))
            0: begin
                lo = 9'd0;
                hi = 9'd255;
            end
            1: begin
                lo = 9'($urandom_range(0, 255));
                hi = 9'($urandom_range(0, int'(lo)));
            end
            2: begin
                lo = 9'($urandom_range(0, 511));
                hi = 9'($urandom_range(0, 511));
            end
            default: begin
                lo = 9'($urandom_range(0, 80));
                hi = lo + 9'($urandom_range(1, 100));
            end
        endcase
        for (int k = 0; k < 2; k++) begin
            case ($urandom_range(0, 5))
                0: wgt[k] = 9'd0;
                1: wgt[k] = 9'd256;
                2: wgt[k] = 9'($urandom_range(257, 511));
                default: wgt[k] = 9'($urandom_range(0, 256));
            endcase
        end
        write_reg(CFG_LOW_THR, lo);
        write_reg(CFG_HIGH_THR, hi);
        write_reg(CFG_LOW_WGT, wgt[0]);
        write_reg(CFG_HIGH_WGT, wgt[1]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_pair();
        int d, lo_d, hi_d, p;
        logic [PIX_W-1:0] prev, cur;
        if ($urandom_range(0, 9) < 6) begin
            lo_d = int'(model_low_thr);
            hi_d = (model_high_thr > model_low_thr) ? int'(model_high_thr) + 1 : lo_d + 3;
            if (hi_d > 255) begin
                hi_d = 255;
            end
            d    = $urandom_range(lo_d, hi_d);
            p    = $urandom_range(0, 255 - d);
            prev = PIX_W'(p);
            cur  = PIX_W'(p + d);
            if ($urandom_range(0, 1) == 1) begin
                prev = PIX_W'(p + d);
                cur  = PIX_W'(p);
            end
        end else begin
            prev = PIX_W'($urandom);
            cur  = PIX_W'($urandom);
        end
        send_pair(prev, cur, 1'b0, '0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_low_thr  = RST_LOW_THR;
            model_high_thr = RST_HIGH_THR;
            model_low_wgt  = RST_LOW_WGT;
            model_high_wgt = RST_HIGH_WGT;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOW_THR:  model_low_thr  = i_cfg_data[THR_W-1:0];
                    CFG_HIGH_THR: model_high_thr = i_cfg_data[THR_W-1:0];
                    CFG_LOW_WGT:  model_low_wgt  = i_cfg_data;
                    CFG_HIGH_WGT: model_high_wgt = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                blend_expected.push_back(pair_known ? pair_known_pixel
                                                    : blend_pixel(i_previous_pixel,
                                                                  i_current_pixel));
            end
            if (o_valid && !i_stall) begin
                got_pixel = o_blended_pixel;
                if (blend_expected.size() == 0) begin
                    report_mismatch("blended_pixel with no transaction pending",
                                    int'(got_pixel), -1);
                end else begin
                    want_pixel = blend_expected.pop_front();
                    if (got_pixel !== want_pixel) begin
                        report_mismatch("blended_pixel", int'(got_pixel), int'(want_pixel));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 34);
        end
    end

    initial begin
        t_row row;
        int   random_start;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_previous_pixel = '0;
        i_current_pixel  = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_LOW_THR;
        i_cfg_data       = '0;
        pair_known       = 1'b0;
        pair_known_pixel = '0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        mismatch_count   = 0;
        pairs_sent       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_ROWS; n++) begin
            row = DIRECTED_ROWS[n];
            if (row.kind == ROW_REG) begin
                wait_idle();
                write_reg(t_cfg_idx'(row.a[CFG_IDX_W-1:0]), row.b);
                i_cfg_valid <= 1'b0;
            end else begin
                send_pair(row.a[PIX_W-1:0], row.b[PIX_W-1:0], row.known, row.pixel);
            end
        end

        random_start = pairs_sent;
        while (pairs_sent - random_start < RANDOM_PAIRS) begin
            wait_idle();
            random_settings();
            repeat ($urandom_range(40, 160)) begin
                quiet <= (pairs_sent - random_start >= 500) &&
                         (pairs_sent - random_start < 800);
                if (pairs_sent - random_start >= 1100) begin
                    hold_req <= 1'b1;
                end
                random_pair();
            end
        end
        quiet <= 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && blend_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/matb_pkg.sv
hw/rtl/matb_weight.sv
hw/rtl/matb_div_stage.sv
hw/rtl/matb_mix.sv
hw/rtl/motion_adaptive_temporal_blend_core.sv
hw/rtl/matb_checker.sv
sim/motion_adaptive_temporal_blend_core_tb.sv
